>>> rtl/spcd_pkg.sv
package spcd_pkg;

  // Input transaction: one begin marker or one encoded byte.
  typedef struct packed {
    logic       action;
    logic [7:0] encoded_byte;
  } req_t;

  // Final stream status codes.
  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_OVER_LIMIT  = 3'd1,
    STAT_TRUNCATED   = 3'd2,
    STAT_BAD_ESCAPE  = 3'd3,
    STAT_EXTRA_DATA  = 3'd4,
    STAT_BAD_PADDING = 3'd5
  } status_e;

  // Result transaction: a decoded byte or the final status of a stream.
  typedef struct packed {
    logic       is_status;
    logic [7:0] decoded_byte;
    status_e    status;
    logic       last;
  } res_t;

  // Input action codes.
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE           = 2'd0;
  localparam logic [1:0] CFG_SYMBOL_COUNT   = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_ENCODED_LENGTH = 2'd3;

  // Mode register values.
  localparam logic MODE_STRICT  = 1'b0;
  localparam logic MODE_PREVIEW = 1'b1;

  // Commands passed from the front end to the decode engine.
  typedef enum logic [1:0] {
    CMD_BEGIN_OK,
    CMD_BEGIN_OVER,
    CMD_BEGIN_TRUNC,
    CMD_DATA
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

  // Stream phase.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_DONE
  } phase_e;

  // Decode engine sequencer.
  typedef enum logic {
    BK_FETCH,
    BK_STEP
  } bk_state_e;

  // Outcome of looking at the head of the bit buffer.
  typedef enum logic [1:0] {
    DEC_MORE,
    DEC_SYM,
    DEC_ESC
  } dec_kind_e;

  typedef struct packed {
    dec_kind_e  kind;
    logic [7:0] sym;
    logic [3:0] len;
  } dec_t;

  localparam int unsigned BufWidth  = 20;
  localparam int unsigned HeldWidth = 5;

  // Code structure.
  localparam logic [2:0] SHORT3_LIMIT = 3'd5;
  localparam logic [2:0] FOUR_PREFIX  = 3'd5;
  localparam logic [4:0] ESC_PREFIX   = 5'd31;
  localparam logic [5:0] SIX_BASE     = 6'd48;
  localparam logic [4:0] FULL_HELD    = 5'd12;
  localparam logic [4:0] PAD_MAX      = 5'd7;

  // Symbol tables: " etao", "in", "shrdlucmfwypbg".
  localparam logic [7:0] SYM3 [5] = '{8'h20, 8'h65, 8'h74, 8'h61, 8'h6F};
  localparam logic [7:0] SYM4 [2] = '{8'h69, 8'h6E};
  localparam logic [7:0] SYM6 [14] = '{8'h73, 8'h68, 8'h72, 8'h64, 8'h6C, 8'h75, 8'h63,
                                       8'h6D, 8'h66, 8'h77, 8'h79, 8'h70, 8'h62, 8'h67};

  // True when a byte value has one of the short codes.
  function automatic logic has_short_code(input logic [7:0] v);
    logic r;
    r = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (SYM3[i] == v) r = 1'b1;
    end
    for (int i = 0; i < 2; i++) begin
      if (SYM4[i] == v) r = 1'b1;
    end
    for (int i = 0; i < 14; i++) begin
      if (SYM6[i] == v) r = 1'b1;
    end
    return r;
  endfunction

  // Looks at the oldest held bits and decodes one symbol if it is complete.
  function automatic dec_t decode_symbol(input logic [BufWidth-1:0] bits,
                                         input logic [HeldWidth-1:0] held);
    dec_t       d;
    logic [2:0] f;
    logic [3:0] v4;
    logic [4:0] p;
    logic [5:0] v6;
    logic [7:0] lit;
    logic [3:0] idx;
    d.kind = DEC_MORE;
    d.sym  = 8'h00;
    d.len  = 4'd0;
    f   = 3'(bits >> (held - 5'd3));
    v4  = 4'(bits >> (held - 5'd4));
    p   = 5'(bits >> (held - 5'd5));
    v6  = 6'(bits >> (held - 5'd6));
    lit = 8'(bits >> (held - 5'd13));
    idx = 4'(v6 - SIX_BASE);
    if (held >= 5'd3) begin
      if (f < SHORT3_LIMIT) begin
        d.kind = DEC_SYM;
        d.sym  = SYM3[f];
        d.len  = 4'd3;
      end else if (f == FOUR_PREFIX) begin
        if (held >= 5'd4) begin
          d.kind = DEC_SYM;
          d.sym  = SYM4[v4[0]];
          d.len  = 4'd4;
        end
      end else if (p != ESC_PREFIX) begin
        if (held >= 5'd6) begin
          d.kind = DEC_SYM;
          d.sym  = SYM6[idx];
          d.len  = 4'd6;
        end
      end else if (held >= 5'd13) begin
        if (has_short_code(lit)) begin
          d.kind = DEC_ESC;
        end else begin
          d.kind = DEC_SYM;
          d.sym  = lit;
          d.len  = 4'd13;
        end
      end
    end
    return d;
  endfunction

endpackage

>>> rtl/spcd_front.sv
module spcd_front import spcd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH  = 20,
  parameter int unsigned LENGTH_WIDTH = 21
) (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  req_t                    in_data_i,
  input  logic                    mode_i,
  input  logic [COUNT_WIDTH-1:0]  count_i,
  input  logic [COUNT_WIDTH-1:0]  limit_i,
  input  logic [LENGTH_WIDTH-1:0] len_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output cmd_t                    push_data_o
);

  localparam int unsigned CmpWidth =
      (COUNT_WIDTH + 2 > LENGTH_WIDTH + 3) ? COUNT_WIDTH + 2 : LENGTH_WIDTH + 3;

  logic [CmpWidth-1:0] count_x3;
  logic [CmpWidth-1:0] len_x8;
  logic                over_limit;
  logic                too_short;

  // Up-front checks of a begin transaction in strict mode.
  assign count_x3   = CmpWidth'(count_i) + CmpWidth'({count_i, 1'b0});
  assign len_x8     = CmpWidth'({len_i, 3'b000});
  assign over_limit = (mode_i == MODE_STRICT) && (count_i > limit_i);
  assign too_short  = (mode_i == MODE_STRICT) && (count_x3 > len_x8);

  // Accept whenever the command queue has room.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the transaction into a command for the decode engine.
  always_comb begin
    push_data_o.data = in_data_i.encoded_byte;
    if (in_data_i.action == ACT_DATA) begin
      push_data_o.op = CMD_DATA;
    end else if (over_limit) begin
      push_data_o.op = CMD_BEGIN_OVER;
    end else if (too_short) begin
      push_data_o.op = CMD_BEGIN_TRUNC;
    end else begin
      push_data_o.op = CMD_BEGIN_OK;
    end
  end

endmodule

>>> rtl/spcd_cmd_queue.sv
module spcd_cmd_queue import spcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t data_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

>>> rtl/spcd_back.sv
module spcd_back import spcd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH  = 20,
  parameter int unsigned LENGTH_WIDTH = 21
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    mode_i,
  input  logic [COUNT_WIDTH-1:0]  count_i,
  input  logic [COUNT_WIDTH-1:0]  limit_i,
  input  logic [LENGTH_WIDTH-1:0] len_i,
  input  logic                    cmd_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output res_t                    out_data_o
);

  bk_state_e state_q, state_d;
  phase_e    phase_q, phase_d;

  logic [BufWidth-1:0]     bits_q, bits_d;
  logic [HeldWidth-1:0]    held_q, held_d;
  logic [COUNT_WIDTH-1:0]  emitted_q, emitted_d;
  logic [LENGTH_WIDTH-1:0] taken_q, taken_d;
  logic [2:0]              nsym_q, nsym_d;

  logic out_valid_q;
  res_t out_q;
  logic out_ok;
  logic emit;
  res_t emit_res;

  logic [COUNT_WIDTH-1:0] target;
  logic [COUNT_WIDTH-1:0] emitted_inc;
  logic                   reached;
  logic                   reached_next;
  logic                   data_left;
  status_e                pad_status;
  status_e                count_status;
  dec_t                   dec_now;
  dec_t                   dec_next;
  logic [HeldWidth-1:0]   held_next;
  logic [BufWidth-1:0]    bits_next;
  logic                   item_end;

  assign out_ok = !out_valid_q || out_ready_i;

  // Target count, and whether it is reached now or after one more symbol.
  assign target       = (mode_i == MODE_PREVIEW && limit_i < count_i) ? limit_i : count_i;
  assign emitted_inc  = emitted_q + COUNT_WIDTH'(1);
  assign reached      = (emitted_q >= target);
  assign reached_next = (emitted_inc >= target);
  assign data_left    = (taken_q < len_i);

  // Status once the count is reached: leftover data and padding checks.
  always_comb begin
    if (data_left || held_q > PAD_MAX) begin
      pad_status = STAT_EXTRA_DATA;
    end else if (bits_q != '0) begin
      pad_status = STAT_BAD_PADDING;
    end else begin
      pad_status = STAT_OK;
    end
    if (mode_i == MODE_STRICT || emitted_q == count_i) begin
      count_status = pad_status;
    end else begin
      count_status = STAT_OK;
    end
  end

  // Decode the head of the buffer, and look one symbol further ahead.
  assign dec_now   = decode_symbol(bits_q, held_q);
  assign held_next = held_q - HeldWidth'(dec_now.len);
  assign bits_next = bits_q & ((BufWidth'(1) << held_next) - BufWidth'(1));
  assign dec_next  = decode_symbol(bits_next, held_next);

  // The symbol being sent is the last result of its transaction when the next
  // step would stop quietly to wait for another byte.
  assign item_end = !reached_next &&
                    ((nsym_q == 3'd5) || (dec_next.kind == DEC_MORE && data_left));

  // Sequencer: fetch a command, then decode one symbol per cycle while the output register can take it.
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    bits_d    = bits_q;
    held_d    = held_q;
    emitted_d = emitted_q;
    taken_d   = taken_q;
    nsym_d    = nsym_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    emit_res  = '{is_status: 1'b1, decoded_byte: 8'h00, status: STAT_OK, last: 1'b1};
    unique case (state_q)
      BK_FETCH: begin
        if (cmd_valid_i && out_ok) begin
          cmd_pop_o = 1'b1;
          nsym_d    = 3'd0;
          if (cmd_i.op == CMD_DATA) begin
            if (phase_q == PH_RUN && held_q <= FULL_HELD) begin
              bits_d  = {bits_q[BufWidth-9:0], cmd_i.data};
              held_d  = held_q + HeldWidth'(8);
              taken_d = taken_q + LENGTH_WIDTH'(1);
              state_d = BK_STEP;
            end
          end else begin
            bits_d    = '0;
            held_d    = '0;
            emitted_d = '0;
            taken_d   = '0;
            phase_d   = PH_RUN;
            unique case (cmd_i.op)
              CMD_BEGIN_OVER: begin
                emit            = 1'b1;
                emit_res.status = STAT_OVER_LIMIT;
                phase_d         = PH_DONE;
              end
              CMD_BEGIN_TRUNC: begin
                emit            = 1'b1;
                emit_res.status = STAT_TRUNCATED;
                phase_d         = PH_DONE;
              end
              default: begin
                state_d = BK_STEP;
              end
            endcase
          end
        end
      end
      BK_STEP: begin
        if (out_ok) begin
          if (reached) begin
            emit            = 1'b1;
            emit_res.status = count_status;
            phase_d         = PH_DONE;
            state_d         = BK_FETCH;
          end else begin
            unique case (dec_now.kind)
              DEC_ESC: begin
                emit            = 1'b1;
                emit_res.status = STAT_BAD_ESCAPE;
                phase_d         = PH_DONE;
                state_d         = BK_FETCH;
              end
              DEC_SYM: begin
                emit                  = 1'b1;
                emit_res.is_status    = 1'b0;
                emit_res.decoded_byte = dec_now.sym;
                emit_res.last         = item_end;
                bits_d                = bits_next;
                held_d                = held_next;
                emitted_d             = emitted_inc;
                nsym_d                = nsym_q + 3'd1;
                if (item_end) state_d = BK_FETCH;
              end
              default: begin
                if (!data_left) begin
                  emit            = 1'b1;
                  emit_res.status = (mode_i == MODE_STRICT) ? STAT_TRUNCATED : STAT_OK;
                  phase_d         = PH_DONE;
                end
                state_d = BK_FETCH;
              end
            endcase
          end
        end
      end
      default: begin
        state_d = BK_FETCH;
      end
    endcase
  end

  // Sequencer and stream state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_FETCH;
      phase_q   <= PH_IDLE;
      bits_q    <= '0;
      held_q    <= '0;
      emitted_q <= '0;
      taken_q   <= '0;
      nsym_q    <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      bits_q    <= bits_d;
      held_q    <= held_d;
      emitted_q <= emitted_d;
      taken_q   <= taken_d;
      nsym_q    <= nsym_d;
    end
  end

  // Output register: refilled whenever it is empty or being drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ok) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ok && emit) out_q <= emit_res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/short_prefix_code_decoder.sv
// Flow: a transaction is taken into a two-entry command queue. An up-front status goes from the
// queue to the output register at the load step; a decoded byte also passes a decode step.
// Steps: a command is loaded, then its symbols or status are decoded one at a time while the
// output register can take them, by two symbol decoders (head and look-ahead); a byte that completes
// no symbol still takes a decode step, and an up-front status leaves from the load step.
// Reset: asynchronous, active low; clears the configuration, queue, stream state and output.
module short_prefix_code_decoder import spcd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH  = 20,
  parameter int unsigned LENGTH_WIDTH = 21
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_idx_i,
  input  logic [((LENGTH_WIDTH > COUNT_WIDTH) ? LENGTH_WIDTH : COUNT_WIDTH)-1:0] cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  req_t                                   in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output res_t                                   out_data_o
);

  logic                    mode_q;
  logic [COUNT_WIDTH-1:0]  count_q;
  logic [COUNT_WIDTH-1:0]  limit_q;
  logic [LENGTH_WIDTH-1:0] len_q;

  logic q_full;
  logic q_push;
  cmd_t q_push_data;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_STRICT;
      count_q <= '0;
      limit_q <= '0;
      len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:           mode_q  <= cfg_wdata_i[0];
        CFG_SYMBOL_COUNT:   count_q <= cfg_wdata_i[COUNT_WIDTH-1:0];
        CFG_OUTPUT_LIMIT:   limit_q <= cfg_wdata_i[COUNT_WIDTH-1:0];
        CFG_ENCODED_LENGTH: len_q   <= cfg_wdata_i[LENGTH_WIDTH-1:0];
        default:            mode_q  <= mode_q;
      endcase
    end
  end

  // Front end: accepts and classifies transactions.
  spcd_front #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .mode_i      (mode_q),
    .count_i     (count_q),
    .limit_i     (limit_q),
    .len_i       (len_q),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  // Command queue between the front end and the decode engine.
  spcd_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .valid_o     (cmd_valid),
    .pop_i       (cmd_pop),
    .data_o      (cmd)
  );

  // Decode engine with the output register.
  spcd_back #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .count_i     (count_q),
    .limit_i     (limit_q),
    .len_i       (len_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // A stream status always closes the results of its transaction.
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_status |-> out_data_o.last)
    else $error("status result without last");

  // A decoded byte never carries an error code.
  a_symbol_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_status |-> out_data_o.status == STAT_OK)
    else $error("decoded byte with nonzero status");

  // The decode engine only takes commands that are in the queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");
`endif

endmodule
